### src/slid_pkg.sv
package slid_pkg;

	// default list capacity
	localparam int unsigned CAPACITY_DEF = 16;

	// command codes
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// result status codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_REMOVED   = 3'd1;
	localparam logic [2:0] ST_CLEARED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic cmp;
		logic upd;
	} path_ctl_t;

endpackage

### src/slid_ctrl.sv
module slid_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output slid_pkg::path_ctl_t ctl
);

	slid_pkg::state_t state_q;
	slid_pkg::state_t state_nxt;
	logic             done_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			slid_pkg::S_IDLE: begin
				if (start)
					state_nxt = slid_pkg::S_CMP;
			end
			slid_pkg::S_CMP: state_nxt = slid_pkg::S_UPD;
			slid_pkg::S_UPD: state_nxt = slid_pkg::S_IDLE;
			default: state_nxt = slid_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy     = (state_q != slid_pkg::S_IDLE);
		ctl.load = start && (state_q == slid_pkg::S_IDLE);
		ctl.cmp  = (state_q == slid_pkg::S_CMP);
		ctl.upd  = (state_q == slid_pkg::S_UPD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slid_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == slid_pkg::S_UPD);
		end
	end

	assign done = done_q;

	// compare always leads straight into update
	a_cmp_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slid_pkg::S_CMP |=> state_q == slid_pkg::S_UPD)
		else $error("compare not followed by update");

	// result strobe only right after an update
	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == slid_pkg::S_UPD |=> done && !busy)
		else $error("result strobe missing after update");

	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == slid_pkg::S_IDLE)
		else $error("result strobe while busy");

endmodule

### src/slid_path.sv
module slid_path #(
	parameter int unsigned CAPACITY = slid_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slid_pkg::path_ctl_t ctl,
	input  logic [1:0]          command,
	input  logic signed [31:0]  value,
	output logic [2:0]          status,
	output logic [3:0]          position,
	output logic [4:0]          entry_count,
	output logic signed [31:0]  smallest_value,
	output logic                list_empty
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [1:0]         cmd_q;
	logic signed [31:0] val_q;
	logic signed [31:0] cell_q   [CAPACITY];
	logic signed [31:0] cell_nxt [CAPACITY];
	logic [CW-1:0]      count_q;
	logic [CAPACITY-1:0] lt_s1;
	logic [CAPACITY-1:0] eq_s1;
	logic [CAPACITY-1:0] lt_w;
	logic [CAPACITY-1:0] eq_w;
	logic [CAPACITY-1:0] ins_oh;
	logic [CAPACITY-1:0] del_oh;
	logic [2:0]         status_q;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      ins_idx;
	logic [IW-1:0]      del_idx;
	logic               full;
	logic               found;

	assign full  = (count_q == CW'(CAPACITY));
	assign found = |eq_s1;

	// one compare and one shift mux per cell
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic vld;
		logic signed [31:0] prev_w;
		logic signed [31:0] next_w;
		logic lt_prev;
		logic eq_prev;

		assign vld     = (CW'(i) < count_q);
		assign lt_w[i] = vld && (cell_q[i] < val_q);
		assign eq_w[i] = vld && (cell_q[i] == val_q);

		if (i == 0) begin : g_first
			assign prev_w  = val_q;
			assign lt_prev = 1'b1;
			assign eq_prev = 1'b0;
		end else begin : g_rest
			assign prev_w  = cell_q[i-1];
			assign lt_prev = lt_s1[i-1];
			assign eq_prev = eq_s1[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_w = cell_q[i];
		end else begin : g_inner
			assign next_w = cell_q[i+1];
		end

		// entries equal to the operand sit next to each other
		assign ins_oh[i] = !lt_s1[i] && lt_prev;
		assign del_oh[i] = eq_s1[i] && !eq_prev;

		always_comb begin
			cell_nxt[i] = cell_q[i];
			case (cmd_q)
				slid_pkg::CMD_INSERT: begin
					if (!full && !lt_s1[i])
						cell_nxt[i] = ins_oh[i] ? val_q : prev_w;
				end
				slid_pkg::CMD_DELETE: begin
					if (found && !lt_s1[i])
						cell_nxt[i] = next_w;
				end
				default: cell_nxt[i] = cell_q[i];
			endcase
		end
	end

	// one-hot to index
	always_comb begin
		ins_idx = '0;
		del_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			ins_idx = ins_idx | (ins_oh[i] ? IW'(i) : '0);
			del_idx = del_idx | (del_oh[i] ? IW'(i) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			val_q <= value;
		end
		if (ctl.cmp) begin
			lt_s1 <= lt_w;
			eq_s1 <= eq_w;
		end
		if (ctl.upd)
			cell_q <= cell_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= slid_pkg::ST_NOT_FOUND;
			pos_q    <= '0;
		end else if (ctl.upd) begin
			status_q <= slid_pkg::ST_NOT_FOUND;
			pos_q    <= '0;
			case (cmd_q)
				slid_pkg::CMD_INSERT: begin
					if (full) begin
						status_q <= slid_pkg::ST_FULL;
					end else begin
						status_q <= slid_pkg::ST_INSERTED;
						pos_q    <= ins_idx;
						count_q  <= count_q + CW'(1);
					end
				end
				slid_pkg::CMD_DELETE: begin
					if (found) begin
						status_q <= slid_pkg::ST_REMOVED;
						pos_q    <= del_idx;
						count_q  <= count_q - CW'(1);
					end
				end
				slid_pkg::CMD_CLEAR: begin
					status_q <= slid_pkg::ST_CLEARED;
					count_q  <= '0;
				end
				default: status_q <= slid_pkg::ST_NOT_FOUND;
			endcase
		end
	end

	assign status         = status_q;
	assign position       = 4'(pos_q);
	assign entry_count    = 5'(count_q);
	assign list_empty     = (count_q == '0);
	assign smallest_value = (count_q != '0) ? cell_q[0] : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.upd |=> $stable(count_q))
		else $error("entry count changed outside update");

	a_ins_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd && cmd_q == slid_pkg::CMD_INSERT && !full |-> $onehot(ins_oh))
		else $error("insert slot not unique");

endmodule

### src/sorted_list_insert_delete_top.sv
// channel | signals                                        | transaction when
// --------+------------------------------------------------+---------------------------
// command | start, busy, command, value                    | start high and busy low
// result  | done, status, position, entry_count,           | done high, one cycle only
//         | smallest_value, list_empty                     |
//
// after acceptance the compare state checks the operand against every held entry in
// parallel, and the update state after it shifts the entries and updates the count
// busy is high in those two states; the result strobe is registered from the update
// state and shows with busy low, so a new command may already be taken with it;
// no new command is taken while busy
// arst_n clears the controller, the entry count, the status and the position; the stored
// entries are not cleared and are only read below the count
// the receiver cannot stall: a result is shown once and held until the next
module sorted_list_insert_delete_top #(
	parameter int unsigned CAPACITY = slid_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         command,
	input  logic signed [31:0] value,
	output logic               done,
	output logic [2:0]         status,
	output logic [3:0]         position,
	output logic [4:0]         entry_count,
	output logic signed [31:0] smallest_value,
	output logic               list_empty
);

	// load, compare and update strobes from the controller
	slid_pkg::path_ctl_t ctl;

	slid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// row of entry cells with per-cell compare and shift
	slid_path #(
		.CAPACITY (CAPACITY)
	) u_path (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.command        (command),
		.value          (value),
		.status         (status),
		.position       (position),
		.entry_count    (entry_count),
		.smallest_value (smallest_value),
		.list_empty     (list_empty)
	);

	// an accepted transaction makes the block busy at once
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted transaction did not start");

	// when a result shows an empty list, the front value reads zero and the entry count is zero
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		done && list_empty |-> smallest_value == 32'sd0 && entry_count == 5'd0)
		else $error("empty list shows entries");

endmodule
